/* rtl/stt_pkg.sv */
// Shared types and constants of the stream tracking table.
package stt_pkg;

  localparam int STREAM_SLOTS = 8;
  localparam int ID_W         = 64;
  localparam int ORD_W        = 32;

  typedef enum logic [1:0] {
    CMD_DATA     = 2'd0,
    CMD_TOKEN    = 2'd1,
    CMD_CLOSE    = 2'd2,
    CMD_COMPLETE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_PROTO = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    DLV_NONE  = 2'd0,
    DLV_DATA  = 2'd1,
    DLV_TOKEN = 2'd2
  } delivered_e;

  typedef logic [STREAM_SLOTS-1:0] slot_vec_t;

  typedef struct packed {
    cmd_e             cmd;
    logic [ID_W-1:0]  stream_key;
    logic             start_flag;
    logic             end_flag;
    logic             payload_ok;
  } frame_t;

  // One-hot slot writes for the table
  typedef struct packed {
    logic [ID_W-1:0] id;
    slot_vec_t       open_mask;
    slot_vec_t       free_mask;
    slot_vec_t       inc_mask;
  } tbl_wr_t;

  typedef struct packed {
    status_e          status;
    logic             began;
    delivered_e       delivered;
    logic [ORD_W-1:0] ordinal;
    logic             to_app;
    logic             ended;
  } result_t;

endpackage

/* rtl/stt_table.sv */
// Slot table: open ids and token ordinals, parallel id match.
module stt_table
  import stt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [ID_W-1:0]  query_id,
  input  logic             wr_en,
  input  tbl_wr_t          wr,
  output slot_vec_t        match,
  output slot_vec_t        free_vec,
  output logic [ORD_W-1:0] match_cnt
);

  logic [ID_W-1:0]  open_ids     [STREAM_SLOTS];
  logic [ORD_W-1:0] token_counts [STREAM_SLOTS];

  always_comb begin
    match_cnt = '0;
    for (int i = 0; i < STREAM_SLOTS; i++) begin
      match[i]    = (open_ids[i] == query_id) && (query_id != '0);
      free_vec[i] = (open_ids[i] == '0);
      match_cnt   = match_cnt | (token_counts[i] & {ORD_W{match[i]}});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STREAM_SLOTS; i++) begin
        open_ids[i]     <= '0;
        token_counts[i] <= '0;
      end
    end else if (wr_en) begin
      for (int i = 0; i < STREAM_SLOTS; i++) begin
        if (wr.free_mask[i]) begin
          open_ids[i]     <= '0;
          token_counts[i] <= '0;
        end else begin
          if (wr.open_mask[i]) begin
            open_ids[i] <= wr.id;
          end
          // a freshly opened slot counts from zero
          token_counts[i] <= (wr.open_mask[i] ? '0 : token_counts[i])
                             + ORD_W'(wr.inc_mask[i]);
        end
      end
    end
  end

endmodule

/* rtl/stt_decide.sv */
// Per-frame decision logic: result fields and table writes.
module stt_decide
  import stt_pkg::*;
(
  input  frame_t           frame,
  input  slot_vec_t        match,
  input  slot_vec_t        free_vec,
  input  logic [ORD_W-1:0] match_cnt,
  output tbl_wr_t          wr,
  output result_t          res
);

  slot_vec_t free_lo;
  slot_vec_t slot;
  logic      match_any;
  logic      proceed;
  logic      fresh;
  logic      fail;
  logic      close;

  assign match_any = |match;
  assign free_lo   = free_vec & (~free_vec + slot_vec_t'(1));

  always_comb begin
    wr           = '0;
    wr.id        = frame.stream_key;
    res          = '0;
    res.status   = ST_OK;
    res.delivered = DLV_NONE;
    slot         = '0;
    proceed      = 1'b0;
    fresh        = 1'b0;
    fail         = 1'b0;
    close        = 1'b0;

    if (frame.cmd == CMD_COMPLETE) begin
      wr.free_mask = match;
      res.ended    = match_any;
      res.to_app   = 1'b1;
    end else begin
      if (frame.start_flag) begin
        if ((frame.stream_key == '0) || match_any) begin
          res.status = ST_PROTO;
        end else if (!(|free_vec)) begin
          res.status = ST_FULL;
        end else begin
          wr.open_mask = free_lo;
          res.began    = 1'b1;
          slot         = free_lo;
          fresh        = 1'b1;
          proceed      = 1'b1;
        end
      end else if (!match_any) begin
        res.status = ST_PROTO;
      end else begin
        slot    = match;
        proceed = 1'b1;
      end

      if (proceed) begin
        case (frame.cmd)
          CMD_DATA: begin
            if (frame.payload_ok) res.delivered = DLV_DATA;
            else                  fail = 1'b1;
          end
          CMD_TOKEN: begin
            if (frame.payload_ok) begin
              res.delivered = DLV_TOKEN;
              res.ordinal   = fresh ? '0 : match_cnt;
              res.to_app    = 1'b1;
            end else begin
              fail = 1'b1;
            end
          end
          default: begin
            close      = 1'b1;
            res.to_app = 1'b1;
          end
        endcase

        if (fail) begin
          res.status = ST_PROTO;
        end else if (frame.end_flag || close) begin
          wr.free_mask = slot;
          res.ended    = 1'b1;
        end else if (frame.cmd == CMD_TOKEN) begin
          wr.inc_mask = slot;
        end
      end
    end
  end

endmodule

/* rtl/stream_tracking_table_top.sv */
// Top level of the stream tracking table: frame register, table, result register.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------------------------
//  frame in | start & !busy         | cmd, stream_key, start_flag, end_flag,
//           |                       | payload_ok
//  result   | done (one cycle)      | status, began, delivered, ordinal, to_app,
//           |                       | ended
//
// Each item passes from accept to done through the frame register, then
// through the slot match and decision logic into the result register.
// busy stays low, so a frame can be accepted every cycle; the table write of
// an item lands on the same edge as its result, in time for the next item.
// rst (synchronous) frees all slots and clears all ordinals.
// The receiver cannot stall: a result is shown for one cycle only.
module stream_tracking_table_top
  import stt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          cmd,
  input  logic [ID_W-1:0]     stream_key,
  input  logic                start_flag,
  input  logic                end_flag,
  input  logic                payload_ok,
  output logic                done,
  output logic [1:0]          status,
  output logic                began,
  output logic [1:0]          delivered,
  output logic [ORD_W-1:0]    ordinal,
  output logic                to_app,
  output logic                ended
);

  frame_t           frame;
  logic             frame_valid;
  tbl_wr_t          wr;
  result_t          res;
  result_t          res_q;
  slot_vec_t        match;
  slot_vec_t        free_vec;
  logic [ORD_W-1:0] match_cnt;

  // Single-pass datapath never holds off the sender
  assign busy = 1'b0;

  // Frame register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else begin
      frame_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      frame.cmd        <= cmd_e'(cmd);
      frame.stream_key <= stream_key;
      frame.start_flag <= start_flag;
      frame.end_flag   <= end_flag;
      frame.payload_ok <= payload_ok;
    end
  end

  // Slot table, matched against the registered frame id
  stt_table u_table (
    .clk       (clk),
    .rst       (rst),
    .query_id  (frame.stream_key),
    .wr_en     (frame_valid),
    .wr        (wr),
    .match     (match),
    .free_vec  (free_vec),
    .match_cnt (match_cnt)
  );

  stt_decide u_decide (
    .frame     (frame),
    .match     (match),
    .free_vec  (free_vec),
    .match_cnt (match_cnt),
    .wr        (wr),
    .res       (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_valid) begin
      res_q <= res;
    end
  end

  assign status    = res_q.status;
  assign began     = res_q.began;
  assign delivered = res_q.delivered;
  assign ordinal   = res_q.ordinal;
  assign to_app    = res_q.to_app;
  assign ended     = res_q.ended;

endmodule

/* rtl/stt_checker.sv */
// Port-level checker for the stream tracking table, bound to the top level.
module stt_checker
  import stt_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input logic [1:0]       status,
  input logic [1:0]       delivered,
  input logic [ORD_W-1:0] ordinal,
  input logic             to_app,
  input logic             ended
);

  // every accepted item yields one result, through the frame and result registers
  a_accept_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted item produced no result");

  a_done_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without an accepted item");

  // errors deliver nothing and free nothing
  a_err_quiet: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_OK)) |->
      (delivered == DLV_NONE) && !to_app && !ended && (ordinal == '0))
    else $error("error result carries content");

  a_ord_token: assert property (@(posedge clk) disable iff (rst)
    (done && (delivered != DLV_TOKEN)) |-> (ordinal == '0))
    else $error("ordinal set without token delivery");

endmodule

bind stream_tracking_table_top stt_checker u_stt_checker (.*);
